>>> rtl/core/fqt_pkg.sv
// Package for the failure quarantine table: command and register codes,
// field widths and reset values. No dependencies.
package fqt_pkg;

    localparam int FQT_MAX_ENTRIES = 16;

    localparam int ID_W   = 48;
    localparam int TIME_W = 48;
    localparam int CNT_W  = 8;
    localparam int USE_W  = 5;
    localparam int IDX_W  = 4;

    localparam logic [CNT_W-1:0]  THRESHOLD_RST = 8'd3;
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 48'd1000000;
    localparam logic [USE_W-1:0]  IN_USE_RST    = 5'd0;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_CHECK  = 3'd1,
        CMD_FAIL   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_COUNT  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_IN_USE    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } fsm_t;

endpackage

>>> rtl/core/failure_quarantine_table_unit.sv
// Top level of the failure quarantine table: command channel, register port,
// two memories with registered read data. Depends on fqt_pkg.
//
// Usage:
//   Commands enter on start/busy: an item is taken at a rising edge with start
//   high and busy low. Each command gives exactly one result on allowed,
//   usable_count and status, shown for one cycle while done is high; the
//   receiver cannot stall, so a result is never held back.
//   Load, check, fail, clear and unknown codes go through one memory read,
//   then one read-modify-write step that registers the result. A new command
//   may be accepted in the cycle that shows the previous result.
//   Count walks the active entries through the state memory read port, one
//   entry a cycle, as the state memory has a single read port.
//   Registers are written through cfg_valid/cfg_ready (always ready). The user must
//   write them only while no command is pending; the block does not enforce it.
//   Reset clears registers to defaults and all fail counts and times at once via
//   per-entry valid bits, no clearing pass. Entry identities undefined until loaded.
module failure_quarantine_table_unit
    import fqt_pkg::*;
#(
    parameter int MAX_ENTRIES = FQT_MAX_ENTRIES
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic [IDX_W-1:0]   entry_index,
    input  logic [ID_W-1:0]    target_id,
    input  logic [TIME_W-1:0]  now_time,
    output logic               done,
    output logic               allowed,
    output logic [USE_W-1:0]   usable_count,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [TIME_W-1:0]  cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = CNT_W + TIME_W;

    // configuration
    logic [CNT_W-1:0]  thr_reg;
    logic [TIME_W-1:0] tmo_reg;
    logic [USE_W-1:0]  in_use_reg;
    logic [CW-1:0]     act;

    // command and control
    fsm_t              state_reg, state_next;
    logic [2:0]        cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     acc_reg, acc_next;

    // results
    logic              done_reg, done_next;
    logic              allowed_reg, allowed_next;
    logic [USE_W-1:0]  count_reg, count_next;
    logic              status_reg, status_next;

    // memories
    logic [SW-1:0]     st_mem [MAX_ENTRIES];
    logic [ID_W-1:0]   id_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [SW-1:0]     st_rd_reg;
    logic              vld_rd_reg;
    logic [ID_W-1:0]   id_rd_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              st_wr_en, id_wr_en, clr_all;
    logic [SW-1:0]     st_wr_data;
    logic [AW-1:0]     wr_addr;

    // entry read back, zero where never written since reset or since a clear of that active entry
    logic [CNT_W-1:0]  e_cnt;
    logic [TIME_W-1:0] e_time;

    logic              accept;
    logic              idx_in_range;
    logic              idx_active;

    function automatic logic timed_out(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] first,
        input logic [TIME_W-1:0] tmo
    );
        logic [TIME_W-1:0] elapsed;
        begin
            elapsed = (now >= first) ? (now - first) : '0;
            return elapsed >= tmo;
        end
    endfunction

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign allowed      = allowed_reg;
    assign usable_count = count_reg;
    assign status       = status_reg;

    always_comb
    begin
        if (32'(in_use_reg) < MAX_ENTRIES)
        begin
            act = CW'(in_use_reg);
        end
        else
        begin
            act = CW'(MAX_ENTRIES);
        end
    end

    assign idx_in_range = (32'(idx_reg) < MAX_ENTRIES);
    assign idx_active   = (CW'(idx_reg) < act) && idx_in_range;
    assign e_cnt        = vld_rd_reg ? st_rd_reg[SW-1:TIME_W] : '0;
    assign e_time       = vld_rd_reg ? st_rd_reg[TIME_W-1:0] : '0;
    assign wr_addr      = AW'(idx_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RST;
            tmo_reg    <= TIMEOUT_RST;
            in_use_reg <= IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg    <= cfg_data[CNT_W-1:0];
                REG_TIMEOUT:   tmo_reg    <= cfg_data;
                REG_IN_USE:    in_use_reg <= cfg_data[USE_W-1:0];
                default:       ;
            endcase
        end
    end

    // memories: synchronous read, registered data
    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            st_mem[wr_addr] <= st_wr_data;
        end
        if (id_wr_en)
        begin
            id_mem[wr_addr] <= id_reg;
        end
        if (rd_en)
        begin
            st_rd_reg  <= st_mem[rd_addr];
            vld_rd_reg <= valid_reg[rd_addr];
            id_rd_reg  <= id_mem[rd_addr];
        end
    end

    // per-entry valid bits: an invalid entry reads as zero count and time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (clr_all && (CW'(i) < act))
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            if (st_wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // command register: hold the transfer for the read-modify-write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            idx_reg <= entry_index;
            id_reg  <= target_id;
            now_reg <= now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            acc_reg     <= '0;
            done_reg    <= 1'b0;
            allowed_reg <= 1'b0;
            count_reg   <= '0;
            status_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            acc_reg     <= acc_next;
            done_reg    <= done_next;
            allowed_reg <= allowed_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        pend_next    = 1'b0;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(entry_index);
        st_wr_en     = 1'b0;
        id_wr_en     = 1'b0;
        st_wr_data   = '0;
        clr_all      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_next = '0;
                    acc_next = '0;
                    if (command == CMD_COUNT)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                done_next    = 1'b1;
                allowed_next = 1'b0;
                count_next   = '0;
                status_next  = 1'b0;
                state_next   = S_IDLE;
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        if (idx_in_range)
                        begin
                            st_wr_en = 1'b1;
                            id_wr_en = 1'b1;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    CMD_CHECK:
                    begin
                        allowed_next = 1'b1;
                        if (idx_active && (e_cnt >= thr_reg))
                        begin
                            if (timed_out(now_reg, e_time, tmo_reg))
                            begin
                                st_wr_en = 1'b1;
                            end
                            else
                            begin
                                allowed_next = 1'b0;
                            end
                        end
                    end
                    CMD_FAIL:
                    begin
                        if (idx_active && (id_rd_reg == id_reg))
                        begin
                            st_wr_en = 1'b1;
                            st_wr_data[SW-1:TIME_W] = (e_cnt == '1) ? e_cnt
                                                                    : e_cnt + 1'b1;
                            st_wr_data[TIME_W-1:0]  = (e_cnt == '0) ? now_reg : e_time;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        clr_all = 1'b1;
                    end
                    default:
                    begin
                        status_next = 1'b1;
                    end
                endcase
            end

            S_WALK:
            begin
                // one read issued per cycle; accumulate the previous read
                rd_addr = ptr_reg[AW-1:0];
                if (ptr_reg < act)
                begin
                    rd_en     = 1'b1;
                    ptr_next  = CW'(ptr_reg + 1'b1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if ((e_cnt < thr_reg) || timed_out(now_reg, e_time, tmo_reg))
                    begin
                        acc_next = CW'(acc_reg + 1'b1);
                    end
                end
                else if (!(ptr_reg < act))
                begin
                    done_next    = 1'b1;
                    allowed_next = 1'b0;
                    count_next   = USE_W'(acc_reg);
                    status_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while a command is still in progress");

    a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_wr_en && rd_en))
        else $error("state memory read and write in the same cycle");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ptr_reg <= act) && (acc_reg <= ptr_reg))
        else $error("walk pointer or count beyond active range");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_EXEC) || ($past(state_reg) == S_WALK))
        else $error("result strobe without a command in progress");

endmodule
